// ----- rtl/tcp_connection_demux_defines.svh -----
// shared assertion macros for the connection lookup block
`ifndef TCP_CONNECTION_DEMUX_DEFINES_SVH
`define TCP_CONNECTION_DEMUX_DEFINES_SVH

// same-cycle implication, reset masked
`define TCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcd assertion failed");

// next-cycle implication, reset masked
`define TCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcd assertion failed");

`endif

// ----- rtl/tcd_pkg.sv -----
`default_nettype none
package tcd_pkg;

	localparam int NUM_CONNECTIONS = 16;
	localparam int IDX_W = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;
	localparam int CNT_W = $clog2(NUM_CONNECTIONS + 1);

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_FREE   = 2'd0;
	localparam logic [1:0] ST_LISTEN = 2'd1;

	localparam logic [47:0] ETH_BCAST    = 48'hffff_ffff_ffff;
	localparam logic [31:0] IP_ALL_ONES  = 32'hffff_ffff;
	localparam logic [15:0] IP_HDR_BYTES = 16'd20;

	typedef enum logic [2:0] {
		V_BCAST   = 3'd0,
		V_SHORT   = 3'd1,
		V_RESET   = 3'd2,
		V_EXACT   = 3'd3,
		V_LISTEN  = 3'd4,
		V_WRITTEN = 3'd5
	} verdict_t;

endpackage
`default_nettype wire

// ----- rtl/tcp_connection_demux.sv -----
// Four-tuple TCP connection lookup over a table of tcd_pkg::NUM_CONNECTIONS entries.
// Each beat is either a table write (opcode 0) or a segment lookup (opcode 1), and every
// input beat produces exactly one output beat carrying a verdict and a matched slot.
// Writes, broadcast drops and short-segment drops go straight from the idle state to the
// result state; a lookup walks the table one entry per cycle through a single registered
// read port and one comparator, and stops early when a connected entry matches exactly.
// in_ready is high only while no item is in flight; a finished result sits in the output
// register until taken, and the next item may be accepted meanwhile. The table is empty
// (all entries free) after reset, with no clearing pass.
`default_nettype none
`include "tcp_connection_demux_defines.svh"
module tcp_connection_demux (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [3:0]  slot,
	input  wire logic [1:0]  slot_state,
	input  wire logic [47:0] eth_dst,
	input  wire logic [31:0] ip_src,
	input  wire logic [31:0] ip_dst,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [15:0] ip_length,
	input  wire logic [3:0]  tcp_data_offset,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       verdict,
	output logic [3:0]       match_slot
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} fsm_t;

	fsm_t st_q;

	logic [1:0]  ent_state_q     [tcd_pkg::NUM_CONNECTIONS];
	logic [31:0] ent_local_ip_q  [tcd_pkg::NUM_CONNECTIONS];
	logic [31:0] ent_remote_ip_q [tcd_pkg::NUM_CONNECTIONS];
	logic [15:0] ent_local_port_q  [tcd_pkg::NUM_CONNECTIONS];
	logic [15:0] ent_remote_port_q [tcd_pkg::NUM_CONNECTIONS];

	logic [31:0] ip_src_q, ip_dst_q;
	logic [15:0] src_port_q, dst_port_q;

	logic [tcd_pkg::CNT_W-1:0] cnt_q;
	logic [tcd_pkg::IDX_W-1:0] rd_idx;
	logic issue;

	logic                      rd_vld_s1;
	logic [tcd_pkg::IDX_W-1:0] rd_idx_s1;
	logic [1:0]                rd_state_s1;
	logic [31:0]               rd_lip_s1, rd_rip_s1;
	logic [15:0]               rd_lport_s1, rd_rport_s1;

	logic                      picked_q;
	logic [tcd_pkg::IDX_W-1:0] pick_q;
	tcd_pkg::verdict_t         res_verdict_q;
	logic [3:0]                res_slot_q;

	logic              out_valid_q;
	tcd_pkg::verdict_t out_verdict_q;
	logic [3:0]        out_slot_q;

	logic in_acc, is_write, is_bcast, is_short, slot_ok, wr_en;
	logic [tcd_pkg::IDX_W-1:0] wr_idx;
	logic hit_exact, hit_listen, last_entry;

	assign in_ready = (st_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign is_write = (opcode == tcd_pkg::OP_WRITE);
	assign is_bcast = (eth_dst == tcd_pkg::ETH_BCAST) || (ip_dst == tcd_pkg::IP_ALL_ONES);
	assign is_short = ip_length < (tcd_pkg::IP_HDR_BYTES + {10'd0, tcp_data_offset, 2'b00});
	assign slot_ok  = (32'(slot) < 32'(tcd_pkg::NUM_CONNECTIONS));
	assign wr_en    = in_acc && is_write && slot_ok;
	assign wr_idx   = tcd_pkg::IDX_W'(slot);

	assign rd_idx = cnt_q[tcd_pkg::IDX_W-1:0];
	assign issue  = (st_q == S_SCAN) && (cnt_q != tcd_pkg::CNT_W'(tcd_pkg::NUM_CONNECTIONS));

	// connected entries (and state three) only take exact matches
	assign hit_exact = rd_vld_s1 && rd_state_s1[1]
		&& (rd_rip_s1 == ip_src_q) && (rd_lip_s1 == ip_dst_q)
		&& (rd_rport_s1 == src_port_q) && (rd_lport_s1 == dst_port_q);
	assign hit_listen = rd_vld_s1 && (rd_state_s1 == tcd_pkg::ST_LISTEN)
		&& (rd_lport_s1 == dst_port_q)
		&& ((rd_lip_s1 == ip_dst_q) || ((rd_lip_s1 == 32'd0) && !picked_q));
	assign last_entry = rd_vld_s1
		&& (rd_idx_s1 == tcd_pkg::IDX_W'(tcd_pkg::NUM_CONNECTIONS - 1));

	// entry state table, cleared to free on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tcd_pkg::NUM_CONNECTIONS; i++) begin
				ent_state_q[i] <= tcd_pkg::ST_FREE;
			end
		end else if (wr_en) begin
			ent_state_q[wr_idx] <= slot_state;
		end
	end

	// payload table and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_local_ip_q[wr_idx]    <= ip_dst;
			ent_remote_ip_q[wr_idx]   <= ip_src;
			ent_local_port_q[wr_idx]  <= dst_port;
			ent_remote_port_q[wr_idx] <= src_port;
		end
		rd_idx_s1   <= rd_idx;
		rd_state_s1 <= ent_state_q[rd_idx];
		rd_lip_s1   <= ent_local_ip_q[rd_idx];
		rd_rip_s1   <= ent_remote_ip_q[rd_idx];
		rd_lport_s1 <= ent_local_port_q[rd_idx];
		rd_rport_s1 <= ent_remote_port_q[rd_idx];
		if (in_acc) begin
			ip_src_q   <= ip_src;
			ip_dst_q   <= ip_dst;
			src_port_q <= src_port;
			dst_port_q <= dst_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_IDLE;
			cnt_q         <= '0;
			rd_vld_s1     <= 1'b0;
			picked_q      <= 1'b0;
			pick_q        <= '0;
			res_verdict_q <= tcd_pkg::V_RESET;
			res_slot_q    <= '0;
			out_valid_q   <= 1'b0;
			out_verdict_q <= tcd_pkg::V_RESET;
			out_slot_q    <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_valid_q && out_ready && (st_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q      <= '0;
						picked_q   <= 1'b0;
						pick_q     <= '0;
						res_slot_q <= '0;
						if (is_write) begin
							res_verdict_q <= tcd_pkg::V_WRITTEN;
							st_q          <= S_RESULT;
						end else if (is_bcast) begin
							res_verdict_q <= tcd_pkg::V_BCAST;
							st_q          <= S_RESULT;
						end else if (is_short) begin
							res_verdict_q <= tcd_pkg::V_SHORT;
							st_q          <= S_RESULT;
						end else begin
							st_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit_exact) begin
						res_verdict_q <= tcd_pkg::V_EXACT;
						res_slot_q    <= 4'(rd_idx_s1);
						st_q          <= S_RESULT;
					end else begin
						if (hit_listen) begin
							picked_q <= 1'b1;
							pick_q   <= rd_idx_s1;
						end
						if (last_entry) begin
							if (hit_listen) begin
								res_verdict_q <= tcd_pkg::V_LISTEN;
								res_slot_q    <= 4'(rd_idx_s1);
							end else if (picked_q) begin
								res_verdict_q <= tcd_pkg::V_LISTEN;
								res_slot_q    <= 4'(pick_q);
							end else begin
								res_verdict_q <= tcd_pkg::V_RESET;
								res_slot_q    <= '0;
							end
							st_q <= S_RESULT;
						end
					end
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						out_verdict_q <= res_verdict_q;
						out_slot_q    <= res_slot_q;
						st_q          <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign verdict    = out_verdict_q;
	assign match_slot = out_slot_q;

	`TCD_ASSERT_NEXT(a_rise_from_result, !out_valid,
		!out_valid || ($past(st_q) == S_RESULT))
	`TCD_ASSERT_NEXT(a_scan_starts_clean,
		in_acc && (opcode == tcd_pkg::OP_LOOKUP) && !is_bcast && !is_short,
		(st_q == S_SCAN) && (cnt_q == '0) && !picked_q)
	`TCD_ASSERT_NEXT(a_write_answers, in_acc && is_write,
		(st_q == S_RESULT) && (res_verdict_q == tcd_pkg::V_WRITTEN) && (res_slot_q == '0))
	`TCD_ASSERT_NOW(a_slot_zero_unless_match,
		out_valid && (verdict != tcd_pkg::V_EXACT) && (verdict != tcd_pkg::V_LISTEN),
		match_slot == 4'd0)

endmodule
`default_nettype wire
